@@ src/sha256_pkg.sv @@
// sha256 shared types, constants and rotate helper
// no dependencies
`timescale 1ns / 1ps
package sha256_pkg;
	typedef struct packed {
		logic [31:0] data_word;
		logic [2:0]  byte_count;
		logic        last_flag;
	} in_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_digest;
	} out_item_t;

	// front-to-back command: a full block, optionally the final one
	typedef struct packed {
		logic [511:0] block;
		logic         final_blk;
	} blk_cmd_t;

	localparam logic [31:0] IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

	localparam logic [31:0] K [64] = '{
		32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
		32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
		32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
		32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
		32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
		32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
		32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
		32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
		32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
		32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
		32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam logic [5:0] LEN_POS  = 6'd56;

	function automatic logic [31:0] ror(input logic [31:0] x, input int n);
		ror = (x >> n) | (x << (32 - n));
	endfunction
endpackage

@@ src/sha256_message_hasher_core.sv @@
// sha-256 streaming hasher top level: byte packer front, compression back
// depends on sha256_pkg, sha256_front, sha256_back
// a word beat is accepted while full is low; each full block is compressed in the round unit
// at one round per cycle, and that round loop sets the throughput
// after the last beat the first digest word waits for any previous block still in the
// round unit, then for one or two padding blocks
// front holds one pending block while the back compresses the previous one
// reset loads the initial hash values and clears the block and bit count
`timescale 1ns / 1ps
module sha256_message_hasher_core import sha256_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	output logic      full,
	input  in_item_t  in_item,
	output logic      empty,
	input  logic      pop,
	output out_item_t out_item
);
	logic     cmd_valid, cmd_ready;
	blk_cmd_t cmd;

	sha256_front u_front (.clk, .arst_n, .push, .full, .in_item,
		.cmd_valid, .cmd_ready, .cmd);
	sha256_back u_back (.clk, .arst_n, .cmd_valid, .cmd_ready, .cmd,
		.empty, .pop, .out_item);
endmodule

@@ src/sha256_front.sv @@
// front: packs message bytes into blocks and builds padding blocks
// depends on sha256_pkg
`timescale 1ns / 1ps
module sha256_front import sha256_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	output logic     full,
	input  in_item_t in_item,
	output logic     cmd_valid,
	input  logic     cmd_ready,
	output blk_cmd_t cmd
);
	typedef enum logic [1:0] {S_FILL, S_PAD1, S_PAD2} state_t;

	state_t       state_q;
	logic [511:0] blk_q;
	logic [5:0]   pos_q;
	logic [63:0]  bits_q;
	logic         cmd_valid_q;
	blk_cmd_t     cmd_q;

	logic [2:0]   cnt;
	logic [511:0] nblk;
	logic [5:0]   npos;
	logic         wrap;
	logic [63:0]  nbits;
	logic [511:0] pblk;

	assign cmd_valid = cmd_valid_q;
	assign cmd = cmd_q;
	assign full = (state_q != S_FILL) || (cmd_valid_q && !cmd_ready);

	always_comb begin
		cnt = (in_item.byte_count > 3'd4) ? 3'd4 : in_item.byte_count;
		nblk = blk_q;
		npos = pos_q;
		wrap = 1'b0;
		for (int i = 0; i < 4; i++) begin
			if (3'(i) < cnt) begin
				nblk[511 - 8*npos -: 8] = in_item.data_word[31 - 8*i -: 8];
				if (npos == 6'd63) wrap = 1'b1;
				npos = npos + 6'd1;
			end
		end
		nbits = bits_q + 64'({cnt, 3'b000});
		// pending bytes with the pad marker after them
		pblk = blk_q;
		pblk[511 - 8*pos_q -: 8] = PAD_BYTE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_FILL;
			pos_q <= '0;
			bits_q <= '0;
			cmd_valid_q <= 1'b0;
			blk_q <= '0;
			cmd_q <= '0;
		end else begin
			if (cmd_valid_q && cmd_ready) cmd_valid_q <= 1'b0;
			unique case (state_q)
				S_FILL: begin
					if (push && !full) begin
						// block filled by this word: flush it, any leftovers start the next
						if (wrap) begin
							cmd_valid_q <= 1'b1;
							cmd_q.final_blk <= 1'b0;
							for (int b = 0; b < 64; b++)
								cmd_q.block[511 - 8*b -: 8] <=
									(6'(b) < npos) ?
									blk_q[511 - 8*b -: 8] : nblk[511 - 8*b -: 8];
							for (int b = 0; b < 64; b++)
								blk_q[511 - 8*b -: 8] <=
									(6'(b) < npos) ? nblk[511 - 8*b -: 8] : 8'h00;
						end else begin
							blk_q <= nblk;
						end
						pos_q <= npos;
						bits_q <= nbits;
						if (in_item.last_flag) state_q <= S_PAD1;
					end
				end
				S_PAD1: begin
					if (!cmd_valid_q || cmd_ready) begin
						cmd_valid_q <= 1'b1;
						if (pos_q >= LEN_POS) begin
							cmd_q.block <= pblk;
							cmd_q.final_blk <= 1'b0;
							blk_q <= '0;
							state_q <= S_PAD2;
						end else begin
							cmd_q.block <= {pblk[511:64], bits_q};
							cmd_q.final_blk <= 1'b1;
							blk_q <= '0;
							pos_q <= '0;
							bits_q <= '0;
							state_q <= S_FILL;
						end
					end
				end
				S_PAD2: begin
					if (!cmd_valid_q || cmd_ready) begin
						cmd_valid_q <= 1'b1;
						cmd_q.block <= {448'd0, bits_q};
						cmd_q.final_blk <= 1'b1;
						pos_q <= '0;
						bits_q <= '0;
						state_q <= S_FILL;
					end
				end
				default: state_q <= S_FILL;
			endcase
		end
	end
endmodule

@@ src/sha256_back.sv @@
// back: 64-round compression, one round per cycle, and digest output queue
// depends on sha256_pkg
`timescale 1ns / 1ps
module sha256_back import sha256_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_ready,
	input  blk_cmd_t  cmd,
	output logic      empty,
	input  logic      pop,
	output out_item_t out_item
);
	typedef enum logic [1:0] {B_IDLE, B_RUN, B_ADD, B_OUT} state_t;

	state_t      state_q;
	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic [31:0] w_q [16];
	logic [5:0]  rnd_q;
	logic        fin_q;
	logic [2:0]  oidx_q;

	logic [31:0] t1, t2, s0, s1, wn;

	assign cmd_ready = (state_q == B_IDLE);
	assign empty = (state_q != B_OUT);
	assign out_item.digest_word = h_q[oidx_q];
	assign out_item.word_index = oidx_q;
	assign out_item.last_digest = (oidx_q == 3'd7);

	always_comb begin
		t1 = v_q[7] + (ror(v_q[4], 6) ^ ror(v_q[4], 11) ^ ror(v_q[4], 25))
			+ ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) + K[rnd_q] + w_q[0];
		t2 = (ror(v_q[0], 2) ^ ror(v_q[0], 13) ^ ror(v_q[0], 22))
			+ ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
		s0 = ror(w_q[1], 7) ^ ror(w_q[1], 18) ^ (w_q[1] >> 3);
		s1 = ror(w_q[14], 17) ^ ror(w_q[14], 19) ^ (w_q[14] >> 10);
		wn = s1 + w_q[9] + s0 + w_q[0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			for (int i = 0; i < 8; i++) h_q[i] <= IV[i];
			rnd_q <= '0;
			fin_q <= 1'b0;
			oidx_q <= '0;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (cmd_valid) begin
						for (int i = 0; i < 16; i++) w_q[i] <= cmd.block[511 - 32*i -: 32];
						for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
						fin_q <= cmd.final_blk;
						rnd_q <= '0;
						state_q <= B_RUN;
					end
				end
				B_RUN: begin
					// message schedule slides as a 16-word window
					for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
					w_q[15] <= wn;
					for (int i = 1; i < 8; i++)
						if (i != 4) v_q[i] <= v_q[i-1];
					v_q[4] <= v_q[3] + t1;
					v_q[0] <= t1 + t2;
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) state_q <= B_ADD;
				end
				B_ADD: begin
					for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
					oidx_q <= '0;
					state_q <= fin_q ? B_OUT : B_IDLE;
				end
				B_OUT: begin
					if (pop) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd7) begin
							for (int i = 0; i < 8; i++) h_q[i] <= IV[i];
							state_q <= B_IDLE;
						end
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end
endmodule
